// ===== hdl/spectrum_bin_integrator_unit_assert.svh =====
// -----------------------------------------------------------------------------
// spectrum bin integrator assertion macros
// Shared property templates, clocked on clk_i and disabled during reset.
// -----------------------------------------------------------------------------
`ifndef SPECTRUM_BIN_INTEGRATOR_UNIT_ASSERT_SVH
`define SPECTRUM_BIN_INTEGRATOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SBI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbi_pkg.sv =====
// -----------------------------------------------------------------------------
// sbi_pkg
// Types and constants shared by the spectrum bin integrator modules.
// -----------------------------------------------------------------------------
package sbi_pkg;

  // bin storage
  localparam int MAX_BINS   = 64;
  localparam int BIN_W      = $clog2(MAX_BINS);
  localparam int CNT_W      = $clog2(MAX_BINS + 1);

  // field widths
  localparam int SAMPLE_W   = 24;
  localparam int SUM_W      = 48;
  localparam int OUT_IDX_W  = 6;

  // configuration port
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE_ON = 2'd1;
  localparam logic [CFG_W-1:0]     BINS_RESET       = 7'd64;

  // scaling and divider
  localparam int PROD_W     = 63;
  localparam int QUO_W      = SUM_W - 1;
  localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clear_first;
  } in_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [OUT_IDX_W-1:0]    bin_index;
    logic                    last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic acc_load;
    logic acc_write;
    logic out_direct;
    logic pk_rd;
    logic pk_cmp;
    logic sc_rd;
    logic sc_mul;
    logic div_start;
    logic sc_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_last;
    logic norm_on;
    logic out_free;
    logic peak_zero;
    logic div_busy;
    logic sweep_last;
  } dp_sts_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_ACC      = 9'b000000010,
    S_PK_RD    = 9'b000000100,
    S_PK_CMP   = 9'b000001000,
    S_SC_RD    = 9'b000010000,
    S_SC_MUL   = 9'b000100000,
    S_SC_START = 9'b001000000,
    S_SC_DIV   = 9'b010000000,
    S_SC_OUT   = 9'b100000000
  } ctrl_state_e;

endpackage

// ===== hdl/sbi_div.sv =====
// -----------------------------------------------------------------------------
// sbi_div
// Restoring divider, one quotient bit per cycle, with overflow detection.
// -----------------------------------------------------------------------------
module sbi_div import sbi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [SUM_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic              ovf_o,
  output logic [QUO_W-1:0]  quot_o
);

  logic                 run_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [SUM_W-1:0]     rem_q, rem_d;
  logic [QUO_W-1:0]     dq_q, dq_d;
  logic                 ovf_q;
  logic [SUM_W:0]       trial;
  logic                 ge;
  logic [SUM_W-1:0]     top_part;

  // quotient would not fit below 2^QUO_W iff the top part reaches the divisor
  assign top_part = SUM_W'(dividend_i[PROD_W-1:QUO_W]);

  // one shift-and-subtract step
  always_comb begin
    trial = {rem_q, dq_q[QUO_W-1]};
    ge    = trial >= {1'b0, divisor_i};
    rem_d = ge ? SUM_W'(trial - {1'b0, divisor_i}) : SUM_W'(trial);
    dq_d  = {dq_q[QUO_W-2:0], ge};
  end

  // run flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else if (start_i) begin
      run_q <= 1'b1;
    end else if (run_q && cnt_q == DIV_CNT_W'(1)) begin
      run_q <= 1'b0;
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ovf_q <= top_part >= divisor_i;
      rem_q <= top_part;
      dq_q  <= dividend_i[QUO_W-1:0];
      cnt_q <= DIV_CNT_W'(QUO_W);
    end else if (run_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
      cnt_q <= cnt_q - DIV_CNT_W'(1);
    end
  end

  assign busy_o = run_q;
  assign ovf_o  = ovf_q;
  assign quot_o = dq_q;

endmodule

// ===== hdl/sbi_dp.sv =====
// -----------------------------------------------------------------------------
// sbi_dp
// Datapath: configuration, bin sum memory, accumulator, peak and scaling.
// -----------------------------------------------------------------------------
module sbi_dp import sbi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  in_item_t             in_data_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output out_item_t            out_data_o,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o
);

  // configuration
  logic [CFG_W-1:0] bins_q;
  logic             norm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_RESET;
      norm_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BINS_IN_USE:  bins_q <= cfg_data_i;
        REG_NORMALIZE_ON: norm_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective bin count, 1 .. MAX_BINS
  logic [CFG_W-1:0] n_lim;
  logic [CNT_W-1:0] n_eff;

  always_comb begin
    n_lim = bins_q;
    if (bins_q == '0) begin
      n_lim = CFG_W'(1);
    end else if (bins_q > CFG_W'(MAX_BINS)) begin
      n_lim = CFG_W'(MAX_BINS);
    end
  end
  assign n_eff = CNT_W'(n_lim);

  // bin position and current item
  logic [BIN_W-1:0]          binpos_q;
  logic [BIN_W-1:0]          pos_q;
  logic [BIN_W-1:0]          pos_start;
  logic [BIN_W-1:0]          idx_q;
  logic signed [SAMPLE_W-1:0] x_q;
  logic                      is_last;
  logic                      sweep_last;

  assign pos_start  = (in_data_i.clear_first || CNT_W'(binpos_q) >= n_eff) ? '0 : binpos_q;
  assign is_last    = (CNT_W'(pos_q) + CNT_W'(1)) == n_eff;
  assign sweep_last = (CNT_W'(idx_q) + CNT_W'(1)) == n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      binpos_q <= '0;
      idx_q    <= '0;
    end else begin
      if (cmd_i.acc_write) begin
        binpos_q <= is_last ? '0 : BIN_W'(CNT_W'(pos_q) + CNT_W'(1));
      end
      if (cmd_i.pk_cmp || cmd_i.sc_out) begin
        idx_q <= sweep_last ? '0 : BIN_W'(CNT_W'(idx_q) + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) begin
      pos_q <= pos_start;
      x_q   <= in_data_i.sample;
    end
  end

  // bin sum memory with per-entry valid bits; an invalid entry reads as zero
  logic [SUM_W-1:0]    mem [MAX_BINS];
  logic [MAX_BINS-1:0] vld_q;
  logic [SUM_W-1:0]    rd_q;
  logic                rd_vld_q;
  logic [BIN_W-1:0]    raddr;
  logic                mem_re;
  logic [SUM_W-1:0]    acc_sum;

  assign raddr  = cmd_i.acc_load ? pos_start : idx_q;
  assign mem_re = cmd_i.acc_load || cmd_i.pk_rd || cmd_i.sc_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_write) begin
      mem[pos_q] <= acc_sum;
    end
    if (mem_re) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.acc_load && in_data_i.clear_first) begin
        vld_q <= '0;
      end else if (cmd_i.acc_write) begin
        vld_q[pos_q] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[raddr] && !(cmd_i.acc_load && in_data_i.clear_first);
      end
    end
  end

  logic signed [SUM_W-1:0] rd_s;
  assign rd_s = rd_vld_q ? rd_q : '0;

  // saturating accumulate
  logic [SUM_W:0] sum_wide;

  always_comb begin
    sum_wide = {rd_s[SUM_W-1], rd_s} + {{(SUM_W+1-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      acc_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      acc_sum = sum_wide[SUM_W-1:0];
    end
  end

  // peak search, first bin seeds it, later bins replace only if larger
  logic signed [SUM_W-1:0] peak_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.pk_cmp && (idx_q == '0 || rd_s > peak_q)) begin
      peak_q <= rd_s;
    end
  end

  // magnitudes and scaled dividend: |s| * 25600 + |peak| / 2
  logic [SUM_W-1:0]        peak_mag;
  logic [SUM_W-1:0]        s_mag;
  logic [PROD_W-1:0]       s_ext;
  logic [PROD_W-1:0]       prod_q;
  logic signed [SUM_W-1:0] s_q;
  logic                    neg_q;

  assign peak_mag = peak_q[SUM_W-1] ? (~peak_q + SUM_W'(1)) : peak_q;
  assign s_mag    = rd_s[SUM_W-1] ? (~rd_s + SUM_W'(1)) : rd_s;
  assign s_ext    = PROD_W'(s_mag);

  // 25600 = 2^14 + 2^13 + 2^10
  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_mul) begin
      prod_q <= (s_ext << 14) + (s_ext << 13) + (s_ext << 10)
                + PROD_W'(peak_mag >> 1);
      s_q    <= rd_s;
      neg_q  <= rd_s[SUM_W-1] ^ peak_q[SUM_W-1];
    end
  end

  logic             div_busy;
  logic             div_ovf;
  logic [QUO_W-1:0] div_quot;

  sbi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (peak_mag),
    .busy_o     (div_busy),
    .ovf_o      (div_ovf),
    .quot_o     (div_quot)
  );

  // scaled value with saturation
  logic [SUM_W-1:0] quo_ext;
  logic [SUM_W-1:0] sc_value;

  assign quo_ext = SUM_W'(div_quot);

  always_comb begin
    if (peak_q == '0) begin
      sc_value = s_q;
    end else if (div_ovf) begin
      sc_value = neg_q ? SUM_MIN : SUM_MAX;
    end else begin
      sc_value = neg_q ? (~quo_ext + SUM_W'(1)) : quo_ext;
    end
  end

  // output register
  out_item_t out_q;
  logic      out_vld_q;
  logic      out_free;

  assign out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_direct) begin
      out_q.value     <= acc_sum;
      out_q.bin_index <= OUT_IDX_W'(pos_q);
      out_q.last      <= is_last;
    end else if (cmd_i.sc_out) begin
      out_q.value     <= sc_value;
      out_q.bin_index <= OUT_IDX_W'(idx_q);
      out_q.last      <= sweep_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_direct || cmd_i.sc_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // status to controller
  assign sts_o.is_last    = is_last;
  assign sts_o.norm_on    = norm_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.peak_zero  = peak_q == '0;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.sweep_last = sweep_last;

endmodule

// ===== hdl/sbi_ctrl.sv =====
// -----------------------------------------------------------------------------
// sbi_ctrl
// Controller: sequences accumulation, peak search and the scaled burst.
// -----------------------------------------------------------------------------
module sbi_ctrl import sbi_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.acc_load = 1'b1;
          state_d        = S_ACC;
        end
      end
      S_ACC: begin
        if (sts_i.norm_on) begin
          cmd_o.acc_write = 1'b1;
          state_d         = sts_i.is_last ? S_PK_RD : S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.acc_write  = 1'b1;
          cmd_o.out_direct = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_PK_RD: begin
        cmd_o.pk_rd = 1'b1;
        state_d     = S_PK_CMP;
      end
      S_PK_CMP: begin
        cmd_o.pk_cmp = 1'b1;
        state_d      = sts_i.sweep_last ? S_SC_RD : S_PK_RD;
      end
      S_SC_RD: begin
        cmd_o.sc_rd = 1'b1;
        state_d     = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd_o.sc_mul = 1'b1;
        state_d      = sts_i.peak_zero ? S_SC_OUT : S_SC_START;
      end
      S_SC_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_SC_DIV;
      end
      S_SC_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = S_SC_OUT;
        end
      end
      S_SC_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.sc_out = 1'b1;
          state_d      = sts_i.sweep_last ? S_IDLE : S_SC_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// ===== hdl/spectrum_bin_integrator_unit.sv =====
// -----------------------------------------------------------------------------
// spectrum_bin_integrator_unit
// Per-bin spectrum accumulator with optional peak normalization to 100, 8 fractional bits.
//
//   channel   direction  handshake                 payload
//   cfg       in         cfg_we_i                  cfg_idx_i, cfg_data_i
//   in        in         in_valid_i / in_ready_o   in_item_t
//   out       out        out_valid_o / out_ready_i out_item_t
//
// An accumulated sample passes through a memory read, then an add and write back.
// With normalization on, the last bin of a vector starts a peak sweep that reads
// and compares every bin, then each bin is read, scaled and passed through the
// 47-step divider (skipped when the peak is zero). Reset clears all sums at once
// through per-bin valid bits. A stalled output holds the next result back.
// -----------------------------------------------------------------------------
`include "spectrum_bin_integrator_unit_assert.svh"

module spectrum_bin_integrator_unit import sbi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // controller
  sbi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // datapath
  sbi_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts)
  );

  // checks
  `SBI_ASSERT_NEXT(a_one_item_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "input accepted while an item is in work")
  `SBI_ASSERT_SAME(a_div_not_restarted, dp_cmd.div_start, !dp_sts.div_busy, "divider started while busy")
  `SBI_ASSERT_SAME(a_out_load_free, dp_cmd.out_direct || dp_cmd.sc_out, dp_sts.out_free, "output register overwritten")
  `SBI_ASSERT_NEXT(a_burst_ends_last, dp_cmd.sc_out && dp_sts.sweep_last, out_valid_o && out_data_o.last, "scaled burst did not end with last")

endmodule
